// ----- hdl/cycle_stepped_6502_core_defines.svh -----
// assertion macros for the cycle-stepped 6502 core
// used by the top level; no other dependencies
`ifndef CYCLE_STEPPED_6502_CORE_DEFINES_SVH
`define CYCLE_STEPPED_6502_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
	else $error("assertion failed");
`define CS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define CS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define CS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ----- hdl/cs6502_pkg.sv -----
// shared types and constants for the cycle-stepped 6502 core
// no dependencies
package cs6502_pkg;
	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  s;
		logic [7:0]  p;
		logic [15:0] pc;
		logic [7:0]  op;
		logic [7:0]  opnd;
		logic [15:0] ea;
		logic [3:0]  cyc;
		logic [2:0]  last;
		logic        halted;
	} core_t;

	typedef struct packed {
		logic [15:0] addr;
		logic        wr;
		logic        active;
		logic [7:0]  wdata;
	} bus_t;

	localparam logic [15:0] START_DEFAULT = 16'h8000;
	localparam logic [7:0]  STACK_HI      = 8'h01;
	localparam logic [15:0] VECTOR_LO     = 16'hFFFE;
	localparam logic [15:0] VECTOR_HI     = 16'hFFFF;
	localparam logic [3:0]  CYC_RESET     = 4'd8;
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_B = 4;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;
endpackage

// ----- hdl/cycle_stepped_6502_core.sv -----
// cycle-stepped 6502 core: an item's result is registered at the edge that takes it;
// one item per cycle while the output is not stalled; one bus cycle per item.
// the core state register feeds the combinational steps u_run and u_look, in that order.
// reset (arst_n low, async) clears the state registers and out_valid, sets pc to
// 0x8000 (START_DEFAULT), and the first item after reset only primes the pipeline
// depends on cs6502_pkg, cs6502_step and cycle_stepped_6502_core_defines.svh
`include "cycle_stepped_6502_core_defines.svh"
module cycle_stepped_6502_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] bus_address,
	output logic        bus_write,
	output logic        bus_active,
	output logic [7:0]  write_data,
	output logic        jam_flag
);
	// architectural state, advanced once per accepted item
	cs6502_pkg::core_t core_q;
	cs6502_pkg::core_t core_run;
	cs6502_pkg::core_t core_cur;
	cs6502_pkg::core_t core_look;
	cs6502_pkg::bus_t  bus_look;
	cs6502_pkg::bus_t  bus_unused;
	logic              primed_q;
	logic              in_acc;
	logic              out_free;

	// first step: the item's byte answers the previous request
	cs6502_step u_run (
		.cur  (core_q),
		.data (read_data),
		.nxt  (core_run),
		.bus  (bus_unused)
	);

	assign core_cur = primed_q ? core_run : core_q;

	// second step: look ahead with a zero data byte to form the next bus request
	cs6502_step u_look (
		.cur  (core_cur),
		.data (8'h00),
		.nxt  (core_look),
		.bus  (bus_look)
	);

	// output register frees when empty or being taken
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !out_free;
	assign in_acc   = in_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q      <= '0;
			core_q.pc   <= cs6502_pkg::START_DEFAULT;
			core_q.cyc  <= cs6502_pkg::CYC_RESET;
			primed_q    <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (in_acc) begin
				core_q   <= core_cur;
				primed_q <= 1'b1;
			end else if (cfg_we && !primed_q) begin
				// late start address reloads pc until the first item
				core_q.pc <= cfg_wdata;
			end
			if (in_acc) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bus_address <= bus_look.addr;
			bus_write   <= bus_look.wr;
			bus_active  <= bus_look.active;
			write_data  <= bus_look.wdata;
			jam_flag    <= core_cur.halted;
		end
	end

	`CS_ASSERT_IMP(a_jam_internal, clk, arst_n, out_valid && jam_flag, !bus_active)
	`CS_ASSERT_IMP(a_write_active, clk, arst_n, out_valid && bus_write, bus_active)
	`CS_ASSERT_NXT(a_halt_sticky, clk, arst_n, core_q.halted, core_q.halted)
	`CS_ASSERT_IMP(a_read_zero, clk, arst_n, out_valid && !bus_write, write_data == 8'h00)
endmodule

// ----- hdl/cs6502_step.sv -----
// one cycle of the 6502 core: next state and bus request
// depends on cs6502_pkg
module cs6502_step (
	input  cs6502_pkg::core_t cur,
	input  logic [7:0]        data,
	output cs6502_pkg::core_t nxt,
	output cs6502_pkg::bus_t  bus
);
	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[cs6502_pkg::FLAG_Z] = (v == 8'h00);
		r[cs6502_pkg::FLAG_N] = v[7];
		return r;
	endfunction

	function automatic logic [7:0] shifter(input logic [7:0] v, input logic [1:0] kind,
			inout logic [7:0] p);
		logic       cin;
		logic [7:0] r;
		cin = p[cs6502_pkg::FLAG_C];
		case (kind)
			2'd0: begin p[cs6502_pkg::FLAG_C] = v[7]; r = {v[6:0], 1'b0}; end
			2'd1: begin p[cs6502_pkg::FLAG_C] = v[7]; r = {v[6:0], cin}; end
			2'd2: begin p[cs6502_pkg::FLAG_C] = v[0]; r = {1'b0, v[7:1]}; end
			default: begin p[cs6502_pkg::FLAG_C] = v[0]; r = {cin, v[7:1]}; end
		endcase
		p = set_nz(p, r);
		return r;
	endfunction

	function automatic void read_op(inout cs6502_pkg::core_t c, input logic [7:0] v);
		logic [8:0] sum;
		logic [7:0] ov;
		logic [7:0] reg8;
		ov = (c.op inside {8'hE5, 8'hED, 8'hE9, 8'hEB}) ? ~v : v;
		sum = {1'b0, c.a} + {1'b0, ov} + {8'd0, c.p[cs6502_pkg::FLAG_C]};
		reg8 = (c.op inside {8'hE4, 8'hEC, 8'hE0}) ? c.x :
			(c.op inside {8'hC4, 8'hCC, 8'hC0}) ? c.y : c.a;
		case (c.op) inside
			8'h05, 8'h0D, 8'h09: begin c.a = c.a | v; c.p = set_nz(c.p, c.a); end
			8'h25, 8'h2D, 8'h29: begin c.a = c.a & v; c.p = set_nz(c.p, c.a); end
			8'h45, 8'h4D, 8'h49: begin c.a = c.a ^ v; c.p = set_nz(c.p, c.a); end
			8'h65, 8'h6D, 8'h69, 8'hE5, 8'hED, 8'hE9, 8'hEB: begin
				c.p[cs6502_pkg::FLAG_C] = sum[8];
				c.p[cs6502_pkg::FLAG_V] = (sum[7] ^ c.a[7]) & (sum[7] ^ ov[7]);
				c.a = sum[7:0];
				c.p = set_nz(c.p, c.a);
			end
			8'hA5, 8'hAD, 8'hA9: begin c.a = v; c.p = set_nz(c.p, v); end
			8'hA6, 8'hAE, 8'hA2: begin c.x = v; c.p = set_nz(c.p, v); end
			8'hA4, 8'hAC, 8'hA0: begin c.y = v; c.p = set_nz(c.p, v); end
			8'hA7, 8'hAF, 8'hAB: begin c.a = v; c.x = v; c.p = set_nz(c.p, v); end
			8'hC5, 8'hCD, 8'hC9, 8'hE4, 8'hEC, 8'hE0, 8'hC4, 8'hCC, 8'hC0: begin
				c.p[cs6502_pkg::FLAG_C] = (reg8 >= v);
				c.p[cs6502_pkg::FLAG_Z] = (reg8 == v);
				c.p[cs6502_pkg::FLAG_N] = reg8[7] ^ v[7] ^ (reg8[6:0] < v[6:0]);
			end
			8'h24, 8'h2C: begin
				c.p[cs6502_pkg::FLAG_Z] = ((v & c.a) == 8'h00);
				c.p[cs6502_pkg::FLAG_V] = v[6];
				c.p[cs6502_pkg::FLAG_N] = v[7];
			end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] modify(inout cs6502_pkg::core_t c, input logic [7:0] v);
		logic [7:0] r;
		case (c.op) inside
			8'hC6, 8'hCE: begin r = v - 8'd1; c.p = set_nz(c.p, r); end
			8'hE6, 8'hEE: begin r = v + 8'd1; c.p = set_nz(c.p, r); end
			default: r = shifter(v, c.op[6:5], c.p);
		endcase
		return r;
	endfunction

	function automatic void implied_op(inout cs6502_pkg::core_t c);
		case (c.op)
			8'h0A, 8'h2A, 8'h4A, 8'h6A: c.a = shifter(c.a, c.op[6:5], c.p);
			8'h18: c.p[cs6502_pkg::FLAG_C] = 1'b0;
			8'h38: c.p[cs6502_pkg::FLAG_C] = 1'b1;
			8'h58: c.p[cs6502_pkg::FLAG_I] = 1'b0;
			8'h78: c.p[cs6502_pkg::FLAG_I] = 1'b1;
			8'hB8: c.p[cs6502_pkg::FLAG_V] = 1'b0;
			8'hD8: c.p[cs6502_pkg::FLAG_D] = 1'b0;
			8'hF8: c.p[cs6502_pkg::FLAG_D] = 1'b1;
			8'h88: begin c.y = c.y - 8'd1; c.p = set_nz(c.p, c.y); end
			8'hC8: begin c.y = c.y + 8'd1; c.p = set_nz(c.p, c.y); end
			8'hCA: begin c.x = c.x - 8'd1; c.p = set_nz(c.p, c.x); end
			8'hE8: begin c.x = c.x + 8'd1; c.p = set_nz(c.p, c.x); end
			8'h8A: begin c.a = c.x; c.p = set_nz(c.p, c.a); end
			8'h98: begin c.a = c.y; c.p = set_nz(c.p, c.a); end
			8'hA8: begin c.y = c.a; c.p = set_nz(c.p, c.y); end
			8'hAA: begin c.x = c.a; c.p = set_nz(c.p, c.x); end
			8'hBA: begin c.x = c.s; c.p = set_nz(c.p, c.x); end
			8'h9A: c.s = c.x;
			default: ;
		endcase
	endfunction

	always_comb begin
		cs6502_pkg::core_t c;
		logic [15:0] sa;
		c = cur;
		bus = '0;
		sa = {cs6502_pkg::STACK_HI, cur.s};
		if (cur.halted) begin
			// stays put
		end else if (cur.cyc == 4'd1) begin
			bus = '{addr: cur.pc, wr: 1'b0, active: 1'b1, wdata: 8'h00};
			c.opnd = data;
			c.cyc = 4'd2;
			c.last = 3'd2;
		end else if (cur.cyc > {1'b0, cur.last}) begin
			bus = '{addr: cur.pc, wr: 1'b0, active: 1'b1, wdata: 8'h00};
			c.op = data;
			c.pc = cur.pc + 16'd1;
			c.cyc = 4'd1;
		end else begin
			case (cur.op) inside
				8'h00: case (cur.cyc)
					4'd2: begin c.last = 3'd7; c.pc = cur.pc + 16'd1; end
					4'd3: begin
						bus = '{addr: sa, wr: 1'b1, active: 1'b1, wdata: cur.pc[15:8]};
						c.s = cur.s - 8'd1; c.p[cs6502_pkg::FLAG_B] = 1'b1;
					end
					4'd4: begin
						bus = '{addr: sa, wr: 1'b1, active: 1'b1, wdata: cur.pc[7:0]};
						c.s = cur.s - 8'd1;
					end
					4'd5: begin
						bus = '{addr: sa, wr: 1'b1, active: 1'b1, wdata: cur.p};
						c.s = cur.s - 8'd1; c.p[cs6502_pkg::FLAG_I] = 1'b1;
					end
					4'd6: begin
						bus = '{addr: cs6502_pkg::VECTOR_LO, wr: 1'b0, active: 1'b1,
							wdata: 8'h00};
						c.pc[7:0] = data;
					end
					4'd7: begin
						bus = '{addr: cs6502_pkg::VECTOR_HI, wr: 1'b0, active: 1'b1,
							wdata: 8'h00};
						c.pc[15:8] = data;
					end
					default: ;
				endcase
				8'h40: case (cur.cyc)
					4'd2: c.last = 3'd6;
					4'd3: c.s = cur.s + 8'd1;
					4'd4: begin
						bus = '{addr: sa, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.p = data; c.s = cur.s + 8'd1;
					end
					4'd5: begin
						bus = '{addr: sa, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.pc[7:0] = data; c.s = cur.s + 8'd1;
					end
					4'd6: begin
						bus = '{addr: sa, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.pc[15:8] = data;
					end
					default: ;
				endcase
				8'h60: case (cur.cyc)
					4'd2: c.last = 3'd6;
					4'd3: c.s = cur.s + 8'd1;
					4'd4: begin
						bus = '{addr: sa, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.pc[7:0] = data; c.s = cur.s + 8'd1;
					end
					4'd5: begin
						bus = '{addr: sa, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.pc[15:8] = data;
					end
					4'd6: c.pc = cur.pc + 16'd1;
					default: ;
				endcase
				8'h48, 8'h08: begin
					if (cur.cyc == 4'd2) c.last = 3'd3;
					else if (cur.cyc == 4'd3) begin
						bus = '{addr: sa, wr: 1'b1, active: 1'b1,
							wdata: (cur.op == 8'h48) ? cur.a : cur.p};
						c.s = cur.s - 8'd1;
					end
				end
				8'h68, 8'h28: begin
					if (cur.cyc == 4'd2) c.last = 3'd4;
					else if (cur.cyc == 4'd3) c.s = cur.s + 8'd1;
					else if (cur.cyc == 4'd4) begin
						bus = '{addr: sa, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						if (cur.op == 8'h68) begin
							c.a = data; c.p = set_nz(cur.p, data);
						end else c.p = data;
					end
				end
				8'h20: case (cur.cyc)
					4'd2: begin c.last = 3'd6; c.pc = cur.pc + 16'd1; end
					4'd4: begin
						bus = '{addr: sa, wr: 1'b1, active: 1'b1, wdata: cur.pc[15:8]};
						c.s = cur.s - 8'd1;
					end
					4'd5: begin
						bus = '{addr: sa, wr: 1'b1, active: 1'b1, wdata: cur.pc[7:0]};
						c.s = cur.s - 8'd1;
					end
					4'd6: begin
						bus = '{addr: cur.pc, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.pc = {data, cur.opnd};
					end
					default: ;
				endcase
				8'h4C: begin
					if (cur.cyc == 4'd2) begin c.last = 3'd3; c.pc = cur.pc + 16'd1; end
					else if (cur.cyc == 4'd3) begin
						bus = '{addr: cur.pc, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.pc = {data, cur.opnd};
					end
				end
				8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8,
				8'hF8, 8'h88, 8'hC8, 8'hCA, 8'hE8, 8'h8A, 8'h98, 8'hA8, 8'hAA, 8'hBA,
				8'h9A, 8'hEA, 8'h1A, 8'h3A, 8'h5A, 8'h7A, 8'hDA, 8'hFA: begin
					if (cur.cyc == 4'd2) implied_op(c);
				end
				8'h09, 8'h29, 8'h49, 8'h69, 8'hE9, 8'hEB, 8'hA9, 8'hA2, 8'hA0, 8'hAB,
				8'hC9, 8'hE0, 8'hC0, 8'h80, 8'h82, 8'h89, 8'hC2: begin
					if (cur.cyc == 4'd2) begin
						read_op(c, cur.opnd); c.pc = cur.pc + 16'd1;
					end
				end
				8'h0D, 8'h2C, 8'h2D, 8'h4D, 8'h6D, 8'hAC, 8'hAD, 8'hAE, 8'hCC, 8'hCD,
				8'hEC, 8'hED, 8'h0C, 8'hAF,
				8'h0E, 8'h2E, 8'h4E, 8'h6E, 8'hCE, 8'hEE,
				8'h8C, 8'h8D, 8'h8E, 8'h8F: begin
					if (cur.cyc == 4'd2) begin
						c.last = (cur.op[3:0] == 4'hE && cur.op[7:4] != 4'hA &&
							cur.op[7:4] != 4'h8) ? 3'd6 : 3'd4;
						c.pc = cur.pc + 16'd1;
					end else if (cur.cyc == 4'd3) begin
						bus = '{addr: cur.pc, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.ea = {data, cur.opnd};
						c.pc = cur.pc + 16'd1;
					end else if (cur.op[7:4] == 4'h8) begin
						if (cur.cyc == 4'd4) begin
							bus.addr = cur.ea; bus.wr = 1'b1; bus.active = 1'b1;
							case (cur.op)
								8'h8C: bus.wdata = cur.y;
								8'h8D: bus.wdata = cur.a;
								8'h8E: bus.wdata = cur.x;
								default: bus.wdata = cur.a & cur.x;
							endcase
						end
					end else if (c.last == 3'd6) begin
						if (cur.cyc == 4'd4) begin
							bus = '{addr: cur.ea, wr: 1'b0, active: 1'b1, wdata: 8'h00};
							c.opnd = data;
						end else if (cur.cyc == 4'd5) begin
							bus = '{addr: cur.ea, wr: 1'b1, active: 1'b1, wdata: cur.opnd};
							c.opnd = modify(c, cur.opnd);
						end else if (cur.cyc == 4'd6) begin
							bus = '{addr: cur.ea, wr: 1'b1, active: 1'b1, wdata: cur.opnd};
						end
					end else if (cur.cyc == 4'd4) begin
						bus = '{addr: cur.ea, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						read_op(c, data);
					end
				end
				8'h05, 8'h24, 8'h25, 8'h45, 8'h65, 8'hA4, 8'hA5, 8'hA6, 8'hC4, 8'hC5,
				8'hE4, 8'hE5, 8'hA7: begin
					if (cur.cyc == 4'd2) begin c.last = 3'd3; c.pc = cur.pc + 16'd1; end
					else if (cur.cyc == 4'd3) begin
						bus = '{addr: {8'h00, cur.opnd}, wr: 1'b0, active: 1'b1,
							wdata: 8'h00};
						read_op(c, data);
					end
				end
				8'h06, 8'h26, 8'h46, 8'h66, 8'hC6, 8'hE6: case (cur.cyc)
					4'd2: begin
						c.last = 3'd5; c.pc = cur.pc + 16'd1; c.ea = {8'h00, cur.opnd};
					end
					4'd3: begin
						bus = '{addr: cur.ea, wr: 1'b0, active: 1'b1, wdata: 8'h00};
						c.opnd = data;
					end
					4'd4: begin
						bus = '{addr: cur.ea, wr: 1'b1, active: 1'b1, wdata: cur.opnd};
						c.opnd = modify(c, cur.opnd);
					end
					4'd5: bus = '{addr: cur.ea, wr: 1'b1, active: 1'b1, wdata: cur.opnd};
					default: ;
				endcase
				default: c.halted = 1'b1;
			endcase
			c.cyc = cur.cyc + 4'd1;
		end
		nxt = c;
	end
endmodule

// ----- tb/tb_cycle_stepped_6502_core.sv -----
// testbench for cycle_stepped_6502_core: one item per bus cycle, each result checked as it is taken
// depends on cs6502_pkg and the core rtl; holds its own cycle model of the cpu
`timescale 1ns / 100ps
module tb_cycle_stepped_6502_core;

	// opcodes named by mnemonic and addressing form
	localparam logic [7:0] BRK = 8'h00, RTI = 8'h40, RTS = 8'h60, PHA = 8'h48, PHP = 8'h08;
	localparam logic [7:0] PLA = 8'h68, PLP = 8'h28, JSR = 8'h20, JMP = 8'h4C, STP = 8'h02;
	localparam logic [7:0] ASL_A = 8'h0A, ROL_A = 8'h2A, LSR_A = 8'h4A, ROR_A = 8'h6A;
	localparam logic [7:0] CLC = 8'h18, SEC = 8'h38, CLI = 8'h58, SEI = 8'h78, CLV = 8'hB8;
	localparam logic [7:0] CLD = 8'hD8, SED = 8'hF8, DEY = 8'h88, INY = 8'hC8, DEX = 8'hCA;
	localparam logic [7:0] INX = 8'hE8, TXA = 8'h8A, TYA = 8'h98, TAY = 8'hA8, TAX = 8'hAA;
	localparam logic [7:0] TSX = 8'hBA, TXS = 8'h9A, NOP = 8'hEA;
	localparam logic [7:0] NOP_1A = 8'h1A, NOP_3A = 8'h3A, NOP_5A = 8'h5A, NOP_7A = 8'h7A;
	localparam logic [7:0] NOP_DA = 8'hDA, NOP_FA = 8'hFA;
	localparam logic [7:0] ORA_I = 8'h09, AND_I = 8'h29, EOR_I = 8'h49, ADC_I = 8'h69;
	localparam logic [7:0] SBC_I = 8'hE9, SBC_IU = 8'hEB, LDA_I = 8'hA9, LDX_I = 8'hA2;
	localparam logic [7:0] LDY_I = 8'hA0, LAX_I = 8'hAB, CMP_I = 8'hC9, CPX_I = 8'hE0;
	localparam logic [7:0] CPY_I = 8'hC0, NOP_I80 = 8'h80, NOP_I82 = 8'h82, NOP_I89 = 8'h89;
	localparam logic [7:0] NOP_IC2 = 8'hC2;
	localparam logic [7:0] ORA_AB = 8'h0D, BIT_AB = 8'h2C, AND_AB = 8'h2D, EOR_AB = 8'h4D;
	localparam logic [7:0] ADC_AB = 8'h6D, LDY_AB = 8'hAC, LDA_AB = 8'hAD, LDX_AB = 8'hAE;
	localparam logic [7:0] CPY_AB = 8'hCC, CMP_AB = 8'hCD, CPX_AB = 8'hEC, SBC_AB = 8'hED;
	localparam logic [7:0] NOP_AB = 8'h0C, LAX_AB = 8'hAF;
	localparam logic [7:0] ASL_AB = 8'h0E, ROL_AB = 8'h2E, LSR_AB = 8'h4E, ROR_AB = 8'h6E;
	localparam logic [7:0] DEC_AB = 8'hCE, INC_AB = 8'hEE;
	localparam logic [7:0] STY_AB = 8'h8C, STA_AB = 8'h8D, STX_AB = 8'h8E, SAX_AB = 8'h8F;
	localparam logic [7:0] ORA_Z = 8'h05, BIT_Z = 8'h24, AND_Z = 8'h25, EOR_Z = 8'h45;
	localparam logic [7:0] ADC_Z = 8'h65, LDY_Z = 8'hA4, LDA_Z = 8'hA5, LDX_Z = 8'hA6;
	localparam logic [7:0] CPY_Z = 8'hC4, CMP_Z = 8'hC5, CPX_Z = 8'hE4, SBC_Z = 8'hE5;
	localparam logic [7:0] LAX_Z = 8'hA7;
	localparam logic [7:0] ASL_Z = 8'h06, ROL_Z = 8'h26, LSR_Z = 8'h46, ROR_Z = 8'h66;
	localparam logic [7:0] DEC_Z = 8'hC6, INC_Z = 8'hE6;

	typedef enum logic [3:0] {
		G_BRK, G_RTI, G_RTS, G_PUSH, G_PULL, G_JSR, G_JMP, G_IMPL, G_IMM,
		G_ABS_RD, G_ABS_RMW, G_ABS_ST, G_ZP_RD, G_ZP_RMW, G_JAM
	} op_group_t;

	typedef struct packed {
		cs6502_pkg::bus_t bus;
		logic jam;
	} cycle_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  read_data;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] bus_address;
	logic        bus_write;
	logic        bus_active;
	logic [7:0]  write_data;
	logic        jam_flag;

	cycle_stepped_6502_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .read_data(read_data),
		.out_valid(out_valid), .out_stall(out_stall), .bus_address(bus_address),
		.bus_write(bus_write), .bus_active(bus_active), .write_data(write_data),
		.jam_flag(jam_flag)
	);

	// model state of the cpu, its start address and the primed bit
	cs6502_pkg::core_t cpu;
	logic [15:0]       start_addr;
	logic              primed;
	cycle_result_t     pending_bus[$];
	int                sender_idle_pct;
	int                stall_pct;
	bit                failed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- cycle model ----------------

	function automatic op_group_t classify(input logic [7:0] op);
		case (op)
			BRK: return G_BRK;
			RTI: return G_RTI;
			RTS: return G_RTS;
			PHA, PHP: return G_PUSH;
			PLA, PLP: return G_PULL;
			JSR: return G_JSR;
			JMP: return G_JMP;
			ASL_A, ROL_A, LSR_A, ROR_A, CLC, SEC, CLI, SEI, CLV, CLD, SED, DEY, INY, DEX,
			INX, TXA, TYA, TAY, TAX, TSX, TXS, NOP, NOP_1A, NOP_3A, NOP_5A, NOP_7A,
			NOP_DA, NOP_FA: return G_IMPL;
			ORA_I, AND_I, EOR_I, ADC_I, SBC_I, SBC_IU, LDA_I, LDX_I, LDY_I, LAX_I, CMP_I,
			CPX_I, CPY_I, NOP_I80, NOP_I82, NOP_I89, NOP_IC2: return G_IMM;
			ORA_AB, BIT_AB, AND_AB, EOR_AB, ADC_AB, LDY_AB, LDA_AB, LDX_AB, CPY_AB,
			CMP_AB, CPX_AB, SBC_AB, NOP_AB, LAX_AB: return G_ABS_RD;
			ASL_AB, ROL_AB, LSR_AB, ROR_AB, DEC_AB, INC_AB: return G_ABS_RMW;
			STY_AB, STA_AB, STX_AB, SAX_AB: return G_ABS_ST;
			ORA_Z, BIT_Z, AND_Z, EOR_Z, ADC_Z, LDY_Z, LDA_Z, LDX_Z, CPY_Z, CMP_Z, CPX_Z,
			SBC_Z, LAX_Z: return G_ZP_RD;
			ASL_Z, ROL_Z, LSR_Z, ROR_Z, DEC_Z, INC_Z: return G_ZP_RMW;
			default: return G_JAM;
		endcase
	endfunction

	function automatic cs6502_pkg::bus_t bus_read(input logic [15:0] addr);
		cs6502_pkg::bus_t b;
		b = '0;
		b.addr = addr;
		b.active = 1'b1;
		return b;
	endfunction

	function automatic cs6502_pkg::bus_t bus_store(input logic [15:0] addr,
			input logic [7:0] d);
		cs6502_pkg::bus_t b;
		b.addr = addr;
		b.wr = 1'b1;
		b.active = 1'b1;
		b.wdata = d;
		return b;
	endfunction

	function automatic void set_nz(inout cs6502_pkg::core_t c, input logic [7:0] v);
		c.p[cs6502_pkg::FLAG_Z] = (v == 8'h00);
		c.p[cs6502_pkg::FLAG_N] = v[7];
	endfunction

	function automatic void add_with_carry(inout cs6502_pkg::core_t c, input logic [7:0] v);
		logic [8:0] sum;
		sum = {1'b0, c.a} + {1'b0, v} + {8'h00, c.p[cs6502_pkg::FLAG_C]};
		c.p[cs6502_pkg::FLAG_C] = sum[8];
		c.p[cs6502_pkg::FLAG_V] = (sum[7] ^ c.a[7]) & (sum[7] ^ v[7]);
		c.a = sum[7:0];
		set_nz(c, c.a);
	endfunction

	function automatic void compare_reg(inout cs6502_pkg::core_t c, input logic [7:0] r,
			input logic [7:0] v);
		logic [7:0] diff;
		diff = r - v;
		c.p[cs6502_pkg::FLAG_C] = (r >= v);
		c.p[cs6502_pkg::FLAG_Z] = (r == v);
		c.p[cs6502_pkg::FLAG_N] = diff[7];
	endfunction

	// kind from opcode bits 6:5: asl, rol, lsr, ror
	function automatic logic [7:0] shift_rotate(inout cs6502_pkg::core_t c,
			input logic [7:0] v, input logic [1:0] kind);
		logic       cin;
		logic [7:0] r;
		cin = c.p[cs6502_pkg::FLAG_C];
		case (kind)
			2'd0: begin r = {v[6:0], 1'b0}; c.p[cs6502_pkg::FLAG_C] = v[7]; end
			2'd1: begin r = {v[6:0], cin};  c.p[cs6502_pkg::FLAG_C] = v[7]; end
			2'd2: begin r = {1'b0, v[7:1]}; c.p[cs6502_pkg::FLAG_C] = v[0]; end
			default: begin r = {cin, v[7:1]}; c.p[cs6502_pkg::FLAG_C] = v[0]; end
		endcase
		set_nz(c, r);
		return r;
	endfunction

	function automatic logic [7:0] rmw_value(inout cs6502_pkg::core_t c, input logic [7:0] v);
		logic [7:0] r;
		case (c.op)
			DEC_Z, DEC_AB: begin r = v - 8'd1; set_nz(c, r); end
			INC_Z, INC_AB: begin r = v + 8'd1; set_nz(c, r); end
			default: r = shift_rotate(c, v, c.op[6:5]);
		endcase
		return r;
	endfunction

	function automatic void read_op(inout cs6502_pkg::core_t c, input logic [7:0] v);
		case (c.op)
			ORA_Z, ORA_AB, ORA_I: begin c.a = c.a | v; set_nz(c, c.a); end
			AND_Z, AND_AB, AND_I: begin c.a = c.a & v; set_nz(c, c.a); end
			EOR_Z, EOR_AB, EOR_I: begin c.a = c.a ^ v; set_nz(c, c.a); end
			ADC_Z, ADC_AB, ADC_I: add_with_carry(c, v);
			SBC_Z, SBC_AB, SBC_I, SBC_IU: add_with_carry(c, ~v);
			LDA_Z, LDA_AB, LDA_I: begin c.a = v; set_nz(c, v); end
			LDX_Z, LDX_AB, LDX_I: begin c.x = v; set_nz(c, v); end
			LDY_Z, LDY_AB, LDY_I: begin c.y = v; set_nz(c, v); end
			LAX_Z, LAX_AB, LAX_I: begin c.a = v; c.x = v; set_nz(c, v); end
			CMP_Z, CMP_AB, CMP_I: compare_reg(c, c.a, v);
			CPX_Z, CPX_AB, CPX_I: compare_reg(c, c.x, v);
			CPY_Z, CPY_AB, CPY_I: compare_reg(c, c.y, v);
			BIT_Z, BIT_AB: begin
				c.p[cs6502_pkg::FLAG_Z] = ((v & c.a) == 8'h00);
				c.p[cs6502_pkg::FLAG_V] = v[6];
				c.p[cs6502_pkg::FLAG_N] = v[7];
			end
			default: ;
		endcase
	endfunction

	function automatic void implied_op(inout cs6502_pkg::core_t c);
		case (c.op)
			ASL_A, ROL_A, LSR_A, ROR_A: c.a = shift_rotate(c, c.a, c.op[6:5]);
			CLC: c.p[cs6502_pkg::FLAG_C] = 1'b0;
			SEC: c.p[cs6502_pkg::FLAG_C] = 1'b1;
			CLI: c.p[cs6502_pkg::FLAG_I] = 1'b0;
			SEI: c.p[cs6502_pkg::FLAG_I] = 1'b1;
			CLV: c.p[cs6502_pkg::FLAG_V] = 1'b0;
			CLD: c.p[cs6502_pkg::FLAG_D] = 1'b0;
			SED: c.p[cs6502_pkg::FLAG_D] = 1'b1;
			DEY: begin c.y = c.y - 8'd1; set_nz(c, c.y); end
			INY: begin c.y = c.y + 8'd1; set_nz(c, c.y); end
			DEX: begin c.x = c.x - 8'd1; set_nz(c, c.x); end
			INX: begin c.x = c.x + 8'd1; set_nz(c, c.x); end
			TXA: begin c.a = c.x; set_nz(c, c.a); end
			TYA: begin c.a = c.y; set_nz(c, c.a); end
			TAY: begin c.y = c.a; set_nz(c, c.y); end
			TAX: begin c.x = c.a; set_nz(c, c.x); end
			TSX: begin c.x = c.s; set_nz(c, c.x); end
			TXS: c.s = c.x;
			default: ;
		endcase
	endfunction

	// one clock of the cpu: consumes the byte read and gives the next access
	function automatic void cpu_cycle(inout cs6502_pkg::core_t c, input logic [7:0] d,
			output cs6502_pkg::bus_t b);
		logic [3:0]  k;
		logic [15:0] stk;
		b = '0;
		if (c.halted)
			return;
		if (c.cyc == 4'd1) begin
			b = bus_read(c.pc);
			c.opnd = d;
			c.cyc = 4'd2;
			c.last = 3'd2;
			return;
		end
		if (c.cyc > {1'b0, c.last}) begin
			b = bus_read(c.pc);
			c.op = d;
			c.pc = c.pc + 16'd1;
			c.cyc = 4'd1;
			return;
		end
		k = c.cyc;
		stk = {cs6502_pkg::STACK_HI, c.s};
		case (classify(c.op))
			G_BRK: case (k)
				4'd2: begin c.last = 3'd7; c.pc = c.pc + 16'd1; end
				4'd3: begin
					b = bus_store(stk, c.pc[15:8]); c.s = c.s - 8'd1;
					c.p[cs6502_pkg::FLAG_B] = 1'b1;
				end
				4'd4: begin b = bus_store(stk, c.pc[7:0]); c.s = c.s - 8'd1; end
				4'd5: begin
					b = bus_store(stk, c.p); c.s = c.s - 8'd1;
					c.p[cs6502_pkg::FLAG_I] = 1'b1;
				end
				4'd6: begin b = bus_read(cs6502_pkg::VECTOR_LO); c.pc[7:0] = d; end
				4'd7: begin b = bus_read(cs6502_pkg::VECTOR_HI); c.pc[15:8] = d; end
				default: ;
			endcase
			G_RTI: case (k)
				4'd2: c.last = 3'd6;
				4'd3: c.s = c.s + 8'd1;
				4'd4: begin b = bus_read(stk); c.p = d; c.s = c.s + 8'd1; end
				4'd5: begin b = bus_read(stk); c.pc[7:0] = d; c.s = c.s + 8'd1; end
				4'd6: begin b = bus_read(stk); c.pc[15:8] = d; end
				default: ;
			endcase
			G_RTS: case (k)
				4'd2: c.last = 3'd6;
				4'd3: c.s = c.s + 8'd1;
				4'd4: begin b = bus_read(stk); c.pc[7:0] = d; c.s = c.s + 8'd1; end
				4'd5: begin b = bus_read(stk); c.pc[15:8] = d; end
				4'd6: c.pc = c.pc + 16'd1;
				default: ;
			endcase
			G_PUSH:
				if (k == 4'd2)
					c.last = 3'd3;
				else if (k == 4'd3) begin
					b = bus_store(stk, (c.op == PHA) ? c.a : c.p);
					c.s = c.s - 8'd1;
				end
			G_PULL:
				if (k == 4'd2)
					c.last = 3'd4;
				else if (k == 4'd3)
					c.s = c.s + 8'd1;
				else if (k == 4'd4) begin
					b = bus_read(stk);
					if (c.op == PLA) begin
						c.a = d;
						set_nz(c, d);
					end else
						c.p = d;
				end
			G_JSR: case (k)
				4'd2: begin c.last = 3'd6; c.pc = c.pc + 16'd1; end
				4'd4: begin b = bus_store(stk, c.pc[15:8]); c.s = c.s - 8'd1; end
				4'd5: begin b = bus_store(stk, c.pc[7:0]); c.s = c.s - 8'd1; end
				4'd6: begin b = bus_read(c.pc); c.pc = {d, c.opnd}; end
				default: ;
			endcase
			G_JMP:
				if (k == 4'd2) begin
					c.last = 3'd3;
					c.pc = c.pc + 16'd1;
				end else if (k == 4'd3) begin
					b = bus_read(c.pc);
					c.pc = {d, c.opnd};
				end
			G_IMPL:
				if (k == 4'd2)
					implied_op(c);
			G_IMM:
				if (k == 4'd2) begin
					read_op(c, c.opnd);
					c.pc = c.pc + 16'd1;
				end
			G_ABS_RD, G_ABS_RMW, G_ABS_ST:
				if (k == 4'd2) begin
					c.last = (classify(c.op) == G_ABS_RMW) ? 3'd6 : 3'd4;
					c.pc = c.pc + 16'd1;
				end else if (k == 4'd3) begin
					b = bus_read(c.pc);
					c.ea = {d, c.opnd};
					c.pc = c.pc + 16'd1;
				end else if (classify(c.op) == G_ABS_RD) begin
					if (k == 4'd4) begin
						b = bus_read(c.ea);
						read_op(c, d);
					end
				end else if (classify(c.op) == G_ABS_ST) begin
					if (k == 4'd4) case (c.op)
						STY_AB: b = bus_store(c.ea, c.y);
						STA_AB: b = bus_store(c.ea, c.a);
						STX_AB: b = bus_store(c.ea, c.x);
						default: b = bus_store(c.ea, c.a & c.x);
					endcase
				end else case (k)
					4'd4: begin b = bus_read(c.ea); c.opnd = d; end
					4'd5: begin b = bus_store(c.ea, c.opnd); c.opnd = rmw_value(c, c.opnd); end
					4'd6: b = bus_store(c.ea, c.opnd);
					default: ;
				endcase
			G_ZP_RD:
				if (k == 4'd2) begin
					c.last = 3'd3;
					c.pc = c.pc + 16'd1;
				end else if (k == 4'd3) begin
					b = bus_read({8'h00, c.opnd});
					read_op(c, d);
				end
			G_ZP_RMW: case (k)
				4'd2: begin c.last = 3'd5; c.pc = c.pc + 16'd1; c.ea = {8'h00, c.opnd}; end
				4'd3: begin b = bus_read(c.ea); c.opnd = d; end
				4'd4: begin b = bus_store(c.ea, c.opnd); c.opnd = rmw_value(c, c.opnd); end
				4'd5: b = bus_store(c.ea, c.opnd);
				default: ;
			endcase
			default: c.halted = 1'b1;
		endcase
		c.cyc = c.cyc + 4'd1;
	endfunction

	// per accepted item: advance the cpu once primed, then look ahead for the request
	task automatic predict_bus(input logic [7:0] d);
		cs6502_pkg::core_t look;
		cs6502_pkg::bus_t  ignored;
		cycle_result_t     r;
		if (primed)
			cpu_cycle(cpu, d, ignored);
		primed = 1'b1;
		look = cpu;
		cpu_cycle(look, 8'h00, r.bus);
		r.jam = cpu.halted;
		pending_bus.push_back(r);
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		cycle_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bus.size() == 0) begin
				$display("%0t unexpected result addr %h", $time, bus_address);
				failed = 1'b1;
			end else begin
				exp_r = pending_bus.pop_front();
				if (bus_address !== exp_r.bus.addr) begin
					$display("%0t bus_address exp %h got %h", $time, exp_r.bus.addr, bus_address);
					failed = 1'b1;
				end
				if (bus_write !== exp_r.bus.wr) begin
					$display("%0t bus_write exp %b got %b", $time, exp_r.bus.wr, bus_write);
					failed = 1'b1;
				end
				if (bus_active !== exp_r.bus.active) begin
					$display("%0t bus_active exp %b got %b", $time, exp_r.bus.active,
						bus_active);
					failed = 1'b1;
				end
				if (write_data !== exp_r.bus.wdata) begin
					$display("%0t write_data exp %h got %h", $time, exp_r.bus.wdata,
						write_data);
					failed = 1'b1;
				end
				if (jam_flag !== exp_r.jam) begin
					$display("%0t jam_flag exp %b got %b", $time, exp_r.jam, jam_flag);
					failed = 1'b1;
				end
			end
		end
	end

	// receiver back-pressure, rate set per phase
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// ---------------- stimulus ----------------

	// next item carries an opcode when the cpu is about to fetch
	function automatic bit at_fetch();
		return primed && !cpu.halted && cpu.cyc != 4'd1 && cpu.cyc > {1'b0, cpu.last};
	endfunction

	task automatic send_item(input logic [7:0] d);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		read_data <= d;
		do
			@(posedge clk);
		while (in_stall);
		predict_bus(d);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_bus.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_start_address(input logic [15:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_addr = v;
		if (!primed)
			cpu.pc = v;
	endtask

	// late start address: written before the first item, so the first fetch uses it
	task automatic test_start_address();
		write_start_address(16'hFFFF);
		send_item(8'h5A);
		send_item(LDA_I);
	endtask

	// run a list of opcodes; operand and data bytes alternate between extremes
	task automatic run_opcodes(input logic [7:0] ops[]);
		int  i;
		bit  hi;
		i = 0;
		hi = 1'b0;
		while (i < ops.size() || !at_fetch()) begin
			if (at_fetch()) begin
				send_item(ops[i]);
				i++;
			end else begin
				send_item(hi ? 8'hFF : 8'h00);
				hi = !hi;
			end
		end
	endtask

	// extremes: operand bytes of ff and 00, unofficial sbc, rotate through carry,
	// dex, zero-page increment, brk and jsr
	task automatic test_directed();
		logic [7:0] ops[];
		ops = '{SBC_IU, ROR_A, DEX, INC_Z, BRK, JSR};
		run_opcodes(ops);
	endtask

	// known opcodes only, with random operands and data
	task automatic test_random_phase(input int n, input int idle, input int stall);
		logic [7:0] op;
		sender_idle_pct = idle;
		stall_pct = stall;
		repeat (n) begin
			if (at_fetch()) begin
				do
					op = 8'($urandom_range(255));
				while (classify(op) == G_JAM);
				send_item(op);
			end else
				send_item(8'($urandom));
		end
	endtask

	// halting opcode, then the core stays jammed with internal cycles
	task automatic test_jam();
		while (!at_fetch())
			send_item(8'($urandom));
		send_item(STP);
		repeat (12) send_item(8'($urandom));
	endtask

	initial begin
		cpu = '0;
		cpu.pc = cs6502_pkg::START_DEFAULT;
		cpu.cyc = cs6502_pkg::CYC_RESET;
		start_addr = cs6502_pkg::START_DEFAULT;
		primed = 1'b0;
		sender_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'h0000;
		in_valid = 1'b0;
		read_data = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_start_address();
		test_directed();
		test_random_phase(220, 0, 0);
		write_start_address(16'h0000);
		test_random_phase(220, 75, 0);
		// sender holds off until every result is back
		drain_results();
		test_random_phase(220, 0, 75);
		write_start_address(16'($urandom));
		test_random_phase(220, 32, 32);
		test_jam();

		drain_results();
		repeat (5) @(posedge clk);
		if (!failed)
			$display("cycle_stepped_6502_core: match");
		else
			$display("cycle_stepped_6502_core: mismatch");
		$finish;
	end

	// hang guard
	initial begin
		#3000000;
		$display("cycle_stepped_6502_core: mismatch");
		$finish;
	end
endmodule
